// File: hdl/pitp_pkg.sv
// ---------------------------------------------------------------------------
// pitp_pkg
// Shared types, constants and layer tables for the pad position converter.
// ---------------------------------------------------------------------------
`default_nettype none

package pitp_pkg;

    localparam int TABLE_LAYERS = 32;
    localparam int DIV_STEPS    = 40;
    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 6;
    localparam int LAYER_W      = 6;
    localparam int CORDIC_W     = 34;
    localparam int PROD_W       = 46;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int Z_OFFSET_MM  = 143;
    localparam int COORD_MAX    = 65535;
    localparam int COORD_MIN    = -65536;

    typedef struct packed {
        logic              load;
        logic              search_step;
        logic              div_init;
        logic              div_step;
        logic              cordic_init;
        logic              cordic_step;
        logic              mul_go;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic table_end;
    } dp_status_t;

    function automatic logic [7:0] lay_pads(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0: r = 8'd48;    5'd1: r = 8'd48;    5'd2: r = 8'd72;    5'd3: r = 8'd96;
            5'd4: r = 8'd120;   5'd5: r = 8'd144;   5'd6: r = 8'd168;   5'd7: r = 8'd192;
            5'd8: r = 8'd216;   5'd9: r = 8'd240;   5'd10: r = 8'd208;  5'd11: r = 8'd218;
            5'd12: r = 8'd230;  5'd13: r = 8'd214;  5'd14: r = 8'd212;  5'd15: r = 8'd214;
            5'd16: r = 8'd220;  5'd17: r = 8'd224;  5'd18: r = 8'd232;  5'd19: r = 8'd238;
            5'd20: r = 8'd244;  5'd21: r = 8'd232;  5'd22: r = 8'd218;  5'd23: r = 8'd210;
            5'd24: r = 8'd206;  5'd25: r = 8'd202;  5'd26: r = 8'd200;  5'd27: r = 8'd196;
            5'd28: r = 8'd178;  5'd29: r = 8'd130;  5'd30: r = 8'd108;  5'd31: r = 8'd90;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] lay_radius(input logic [4:0] idx);
        logic [10:0] r;
        case (idx)
            5'd0: r = 11'd59;    5'd1: r = 11'd97;    5'd2: r = 11'd135;   5'd3: r = 11'd173;
            5'd4: r = 11'd211;   5'd5: r = 11'd249;   5'd6: r = 11'd287;   5'd7: r = 11'd325;
            5'd8: r = 11'd363;   5'd9: r = 11'd401;   5'd10: r = 11'd446;  5'd11: r = 11'd498;
            5'd12: r = 11'd550;  5'd13: r = 11'd602;  5'd14: r = 11'd654;  5'd15: r = 11'd706;
            5'd16: r = 11'd758;  5'd17: r = 11'd810;  5'd18: r = 11'd862;  5'd19: r = 11'd914;
            5'd20: r = 11'd966;  5'd21: r = 11'd1018; 5'd22: r = 11'd1070; 5'd23: r = 11'd1122;
            5'd24: r = 11'd1174; 5'd25: r = 11'd1226; 5'd26: r = 11'd1278; 5'd27: r = 11'd1330;
            5'd28: r = 11'd1382; 5'd29: r = 11'd1434; 5'd30: r = 11'd1486; 5'd31: r = 11'd1538;
            default: r = 11'd0;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] lay_div(input logic [4:0] idx);
        logic [9:0] r;
        case (idx)
            5'd0: r = 10'd48;   5'd1: r = 10'd48;   5'd2: r = 10'd72;   5'd3: r = 10'd96;
            5'd4: r = 10'd120;  5'd5: r = 10'd144;  5'd6: r = 10'd168;  5'd7: r = 10'd192;
            5'd8: r = 10'd216;  5'd9: r = 10'd240;  5'd10: r = 10'd241; 5'd11: r = 10'd271;
            5'd12: r = 10'd300; 5'd13: r = 10'd330; 5'd14: r = 10'd360; 5'd15: r = 10'd390;
            5'd16: r = 10'd420; 5'd17: r = 10'd449; 5'd18: r = 10'd479; 5'd19: r = 10'd509;
            5'd20: r = 10'd539; 5'd21: r = 10'd569; 5'd22: r = 10'd599; 5'd23: r = 10'd628;
            5'd24: r = 10'd658; 5'd25: r = 10'd688; 5'd26: r = 10'd718; 5'd27: r = 10'd748;
            5'd28: r = 10'd777; 5'd29: r = 10'd807; 5'd30: r = 10'd837; 5'd31: r = 10'd867;
            default: r = 10'd1;
        endcase
        return r;
    endfunction

    // arctangent of 2^-i as a binary angle, 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0: r = 30'h20000000;  5'd1: r = 30'h12E4051E;  5'd2: r = 30'h09FB385B;
            5'd3: r = 30'h051111D4;  5'd4: r = 30'h028B0D43;  5'd5: r = 30'h0145D7E1;
            5'd6: r = 30'h00A2F61E;  5'd7: r = 30'h00517C55;  5'd8: r = 30'h0028BE53;
            5'd9: r = 30'h00145F2F;  5'd10: r = 30'h000A2F98; 5'd11: r = 30'h000517CC;
            5'd12: r = 30'h00028BE6; 5'd13: r = 30'h000145F3; 5'd14: r = 30'h0000A2FA;
            5'd15: r = 30'h0000517D; 5'd16: r = 30'h000028BE; 5'd17: r = 30'h0000145F;
            5'd18: r = 30'h00000A30; 5'd19: r = 30'h00000518; 5'd20: r = 30'h0000028C;
            5'd21: r = 30'h00000146; 5'd22: r = 30'h000000A3; 5'd23: r = 30'h00000051;
            5'd24: r = 30'h00000029; 5'd25: r = 30'h00000014; 5'd26: r = 30'h0000000A;
            5'd27: r = 30'h00000005; 5'd28: r = 30'h00000003; 5'd29: r = 30'h00000001;
            default: r = 30'h0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pitp_ctrl.sv
// ---------------------------------------------------------------------------
// pitp_ctrl
// Sequencer: layer search, angle divide, CORDIC, scaling, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module pitp_ctrl
    import pitp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_ANGLE  = 3'd3;
    localparam logic [2:0] ST_CORDIC = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (status.table_end)
                    state_next = ST_FIN;
                else if (status.hit)
                begin
                    cmd.div_init = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
                else
                    cmd.search_step = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_ANGLE;
            end
            ST_ANGLE:
            begin
                cmd.cordic_init = 1'b1;
                step_next       = '0;
                state_next      = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                step_next       = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_go = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SEARCH))
        else $error("accepted item did not start the layer search");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && out_valid_reg) |-> !out_stall)
        else $error("result overwrote a stalled item");
    a_div_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divider step count overran");
`endif

endmodule

`default_nettype wire

// File: hdl/pitp_dp.sv
// ---------------------------------------------------------------------------
// pitp_dp
// Datapath: layer scan, restoring divider, shared CORDIC, radius scaling.
// ---------------------------------------------------------------------------
`default_nettype none

module pitp_dp
    import pitp_pkg::*;
#(
    parameter int LAYER_COUNT         = 32,
    parameter int COORD_FRACTION_BITS = 6
)
(
    input  wire logic        clk,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    input  wire logic [12:0] pad_number,
    output logic             valid_res,
    output logic [4:0]       layer_index,
    output logic [7:0]       row_index,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_z
);

    localparam int EFF_LAYERS = (LAYER_COUNT < TABLE_LAYERS) ? LAYER_COUNT : TABLE_LAYERS;
    localparam int SH         = 32 - COORD_FRACTION_BITS;
    localparam logic signed [PROD_W:0] RND  = (PROD_W+1)'(1) <<< (SH - 1);
    localparam logic signed [PROD_W:0] ZOFF = (PROD_W+1)'(Z_OFFSET_MM) <<< COORD_FRACTION_BITS;
    localparam logic signed [PROD_W:0] CMAX = (PROD_W+1)'(COORD_MAX);
    localparam logic signed [PROD_W:0] CMIN = (PROD_W+1)'(COORD_MIN);

    logic [12:0]               pad_reg, base_reg;
    logic [LAYER_W-1:0]        layer_reg;
    logic                      found_reg, neg_reg, flip_reg;
    logic [4:0]                lay_sel_reg;
    logic [7:0]                row_reg;
    logic [10:0]               rq_reg;
    logic [9:0]                div_reg;
    logic [10:0]               rem_reg;
    logic [39:0]               num_reg;
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [PROD_W-1:0]  px_reg, pz_reg;
    logic                      valid_res_reg;
    logic [4:0]                layer_out_reg;
    logic [7:0]                row_out_reg;
    logic signed [16:0]        pos_x_reg, pos_z_reg;

    // search
    logic [7:0]  pads_cur;
    logic [13:0] base_sum;
    assign pads_cur = lay_pads(layer_reg[4:0]);
    assign base_sum = {1'b0, base_reg} + {6'b0, pads_cur};
    assign status.hit       = ({1'b0, pad_reg} < base_sum);
    assign status.table_end = (layer_reg == LAYER_W'(EFF_LAYERS));

    // angle numerator
    logic [7:0]        row_new;
    logic signed [9:0] n_val;
    logic [8:0]        mag;
    logic [9:0]        div_new;
    assign row_new = 8'(pad_reg - base_reg);
    assign n_val   = $signed({1'b0, row_new, 1'b1}) - $signed({2'b0, pads_cur});
    assign mag     = n_val[9] ? 9'(-n_val) : n_val[8:0];
    assign div_new = lay_div(layer_reg[4:0]);

    // divider step
    logic [11:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {rem_reg, num_reg[39]};
    assign q_bit  = (rem_sh >= {2'b0, div_reg});

    // angle fold
    logic [31:0] ang, ang_f;
    logic        flip;
    assign ang   = neg_reg ? (32'd0 - num_reg[31:0]) : num_reg[31:0];
    assign flip  = ang[31] ^ ang[30];
    assign ang_f = {ang[31] ^ flip, ang[30:0]};

    // CORDIC step
    logic signed [CORDIC_W-1:0] dx, dy, at;
    assign dx = cy_reg >>> cmd.step[4:0];
    assign dy = cx_reg >>> cmd.step[4:0];
    assign at = $signed({4'b0, atan_turn(cmd.step[4:0])});

    // scaling
    logic signed [CORDIC_W-1:0] s_val, c_val;
    logic signed [PROD_W:0]     rx, rz;
    logic signed [16:0]         cx_out, cz_out;
    assign s_val = flip_reg ? -cy_reg : cy_reg;
    assign c_val = flip_reg ? -cx_reg : cx_reg;
    assign rx = ($signed({px_reg[PROD_W-1], px_reg}) + RND) >>> SH;
    assign rz = (($signed({pz_reg[PROD_W-1], pz_reg}) + RND) >>> SH) - ZOFF;
    assign cx_out = (rx > CMAX) ? 17'(COORD_MAX) : ((rx < CMIN) ? 17'(COORD_MIN) : rx[16:0]);
    assign cz_out = (rz > CMAX) ? 17'(COORD_MAX) : ((rz < CMIN) ? 17'(COORD_MIN) : rz[16:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pad_reg   <= pad_number;
            base_reg  <= '0;
            layer_reg <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.search_step)
        begin
            base_reg  <= base_sum[12:0];
            layer_reg <= layer_reg + 1'b1;
        end
        if (cmd.div_init)
        begin
            found_reg   <= 1'b1;
            lay_sel_reg <= layer_reg[4:0];
            row_reg     <= row_new;
            neg_reg     <= n_val[9];
            div_reg     <= div_new;
            rq_reg      <= lay_radius(layer_reg[4:0]);
            rem_reg     <= '0;
            num_reg     <= {mag, 31'b0} + {31'b0, div_new[9:1]};
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? 11'(rem_sh - {2'b0, div_reg}) : rem_sh[10:0];
            num_reg <= {num_reg[38:0], q_bit};
        end
        if (cmd.cordic_init)
        begin
            flip_reg <= flip;
            cx_reg   <= CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= {{(CORDIC_W-32){ang_f[31]}}, ang_f};
        end
        if (cmd.cordic_step)
        begin
            if (!cz_reg[CORDIC_W-1])
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - at;
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + at;
            end
        end
        if (cmd.mul_go)
        begin
            px_reg <= $signed({1'b0, rq_reg}) * s_val;
            pz_reg <= $signed({1'b0, rq_reg}) * c_val;
        end
        if (cmd.out_load)
        begin
            valid_res_reg <= found_reg;
            layer_out_reg <= found_reg ? lay_sel_reg : 5'd0;
            row_out_reg   <= found_reg ? row_reg : 8'd0;
            pos_x_reg     <= found_reg ? cx_out : 17'sd0;
            pos_z_reg     <= found_reg ? cz_out : 17'sd0;
        end
    end

    assign valid_res   = valid_res_reg;
    assign layer_index = layer_out_reg;
    assign row_index   = row_out_reg;
    assign pos_x       = pos_x_reg;
    assign pos_z       = pos_z_reg;

endmodule

`default_nettype wire

// File: hdl/pad_id_to_position_top.sv
// Accepting edge to out_valid: the layer search, the bit-serial angle divide, the angle
// fold, the 30 CORDIC iterations, the multiply and the output load; a pad past the
// last layer skips the math and goes from the layer search straight to the output load.
// One item at a time; the next is taken in the idle cycle after the result is
// loaded, and a stalled output holds the result load back.
// Reset (rst_n, async, active low) clears the sequencer and out_valid; no clearing pass.
// ---------------------------------------------------------------------------
// pad_id_to_position_top
// Converts a flat pad number of the circular pad plane into layer, row and x/z.
// ---------------------------------------------------------------------------
`default_nettype none

module pad_id_to_position_top
    import pitp_pkg::*;
#(
    parameter int LAYER_COUNT         = 32,
    parameter int COORD_FRACTION_BITS = 6
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [12:0]        pad_number,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    valid_res,
    output logic [4:0]              layer_index,
    output logic [7:0]              row_index,
    output logic signed [16:0]      pos_x,
    output logic signed [16:0]      pos_z
);

    // Commands flow from the sequencer, status back from the datapath.
    dp_cmd_t    cmd;
    dp_status_t status;

    pitp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath holds the item, the divider, the CORDIC and the output register.
    pitp_dp #(
        .LAYER_COUNT         (LAYER_COUNT),
        .COORD_FRACTION_BITS (COORD_FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .pad_number  (pad_number),
        .valid_res   (valid_res),
        .layer_index (layer_index),
        .row_index   (row_index),
        .pos_x       (pos_x),
        .pos_z       (pos_z)
    );

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (pos_x == 17'sd0 && pos_z == 17'sd0
            && layer_index == 5'd0 && row_index == 8'd0))
        else $error("out-of-range pad produced nonzero fields");
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in work");
    a_stalled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pos_x) && $stable(pos_z)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// File: sim/pad_id_to_position_top_tb.sv
// ---------------------------------------------------------------------------
// pad_id_to_position_top_tb
// Drives pad numbers into the pad position converter and checks layer, row
// and x/z against a bit-accurate layer search plus CORDIC predictor.
// ---------------------------------------------------------------------------
`default_nettype none

module pad_id_to_position_top_tb;
    import pitp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC        = 6;
    localparam int  LAYERS      = 32;
    localparam int  VALID_PADS  = 5768;
    localparam int  RANDOM_PADS = 700;
    localparam longint CYCLE_LIMIT = 1200000;
    localparam int  DRAIN_CYCLES = 150;

    // one converted pad
    typedef struct {
        logic        ok;
        logic [4:0]  layer;
        logic [7:0]  row;
        logic [16:0] x;
        logic [16:0] z;
    } pad_pos_t;

    // Reference tables kept local so the prediction does not lean on the package tables.
    localparam int PADS_TBL [32] = '{
        48, 48, 72, 96, 120, 144, 168, 192, 216, 240,
        208, 218, 230, 214, 212, 214, 220, 224, 232, 238,
        244, 232, 218, 210, 206, 202, 200, 196, 178, 130, 108, 90};
    localparam int RAD_TBL [32] = '{
        59, 97, 135, 173, 211, 249, 287, 325, 363, 401,
        446, 498, 550, 602, 654, 706, 758, 810, 862, 914,
        966, 1018, 1070, 1122, 1174, 1226, 1278, 1330, 1382, 1434, 1486, 1538};
    localparam int DIV_TBL [32] = '{
        48, 48, 72, 96, 120, 144, 168, 192, 216, 240,
        241, 271, 300, 330, 360, 390, 420, 449, 479, 509,
        539, 569, 599, 628, 658, 688, 718, 748, 777, 807, 837, 867};
    localparam longint ATAN_TBL [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

    int unsigned errors = 0;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    // >>> on longint is an arithmetic (floor) shift
    function automatic longint sat_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic pad_pos_t locate_pad(input logic [12:0] pad);
        pad_pos_t    r;
        longint      base, n, mag, q, a, z, x, y, dx, dy, px, pz;
        longint      rq, dv;
        logic [31:0] ang;
        int          lay;
        bit          flip;
        r = '{ok: 1'b0, layer: '0, row: '0, x: '0, z: '0};
        base = 0;
        lay = -1;
        for (int l = 0; l < LAYERS; l++) begin
            if (lay < 0 && pad < base + PADS_TBL[l]) begin
                lay = l;
                r.row = 8'(pad - base);
            end
            base += PADS_TBL[l];
        end
        if (lay < 0) return r;
        r.ok = 1'b1;
        r.layer = 5'(lay);
        n = 2 * longint'(r.row) + 1 - PADS_TBL[lay];
        dv = DIV_TBL[lay];
        mag = (n < 0) ? -n : n;
        q = (mag * 64'd2147483648 + dv / 2) / dv;
        a = (n < 0) ? -q : q;
        ang = a[31:0];
        // fold the angle into the right half plane, negate afterwards
        flip = (ang >= 32'h40000000 && ang < 32'hC0000000);
        if (flip) ang = ang - 32'h80000000;
        z = longint'($signed(ang));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        rq = RAD_TBL[lay];
        px = (rq * y + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
        pz = ((rq * x + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC)) - (143 <<< FRAC);
        px = sat_coord(px);
        pz = sat_coord(pz);
        r.x = px[16:0];
        r.z = pz[16:0];
        return r;
    endfunction

    class pad_scoreboard;
        pad_pos_t pending[$];

        function void note_pad(input logic [12:0] pad);
            pending.push_back(locate_pad(pad));
        endfunction

        task check_result(input logic ok, input logic [4:0] layer, input logic [7:0] row,
                          input logic [16:0] x, input logic [16:0] z);
            pad_pos_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item, layer", layer, -1);
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok) report_mismatch("valid_res", ok, e.ok);
            if (layer !== e.layer) report_mismatch("layer_index", layer, e.layer);
            if (row !== e.row) report_mismatch("row_index", row, e.row);
            if (x !== e.x) report_mismatch("pos_x", $signed(x), $signed(e.x));
            if (z !== e.z) report_mismatch("pos_z", $signed(z), $signed(e.z));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [12:0] pad_number = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        valid_res;
    logic [4:0]  layer_index;
    logic [7:0]  row_index;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_z;

    pad_scoreboard sb = new();
    longint cycle_count = 0;
    bit     sink_on = 1'b0;
    int     stall_left = 0;

    pad_id_to_position_top #(
        .LAYER_COUNT        (LAYERS),
        .COORD_FRACTION_BITS(FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pad_number (pad_number),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .valid_res  (valid_res),
        .layer_index(layer_index),
        .row_index  (row_index),
        .pos_x      (pos_x),
        .pos_z      (pos_z)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: one draw in ten picks a long gap, the rest a short one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
        return $urandom_range(0, 3);
    endfunction

    // Hold one pad number on the bus until accepted, optionally idle first.
    // Valid stays up after the accept; the next call with a gap, or drop_valid, lowers it.
    task automatic send_pad(input logic [12:0] pad, input bit allow_gap);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        pad_number <= pad;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // accepted at this edge
        sb.note_pad(pad);
    endtask

    // Drop valid right after an accept.
    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // Pick a random pad: mostly valid ones, some past the last layer.
    function automatic logic [12:0] random_pad();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8) return 13'($urandom_range(0, VALID_PADS - 1));
        if (sel == 8) return 13'($urandom_range(VALID_PADS, 8191));
        return 13'($urandom);
    endfunction

    // Result side: check each accepted item, stall in runs of random length.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(valid_res, layer_index, row_index, pos_x, pos_z);
            if (stall_left > 0)
                stall_left <= stall_left - 1;
            else if (sink_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                stall_left <= gap_len();
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("pad_id_to_position_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int base;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edges of the first, an inner and the last layer, end of table, first pad past
        // the end, the largest pad number and some pads inside the table.
        base = 0;
        send_pad(13'd0, 1'b0);
        send_pad(13'd23, 1'b0);
        send_pad(13'd24, 1'b0);
        send_pad(13'd47, 1'b0);
        send_pad(13'd48, 1'b0);
        for (int l = 0; l < LAYERS; l++) base += PADS_TBL[l];
        send_pad(13'(base - 1), 1'b0);
        send_pad(13'(base - 45), 1'b0);
        send_pad(13'(base - 90), 1'b0);
        send_pad(13'(base), 1'b0);
        send_pad(13'd8191, 1'b0);
        send_pad(13'd4096, 1'b0);
        send_pad(13'h0AAA, 1'b0);
        send_pad(13'h1555, 1'b0);
        send_pad(13'd1403, 1'b0);
        send_pad(13'd1404, 1'b0);

        // Random with stalls on both sides.
        sink_on = 1'b1;
        for (int i = 0; i < RANDOM_PADS; i++) begin
            if (i == RANDOM_PADS / 2) begin
                // hold off until the converter has drained
                drop_valid();
                do @(posedge clk); while (sb.pending.size() != 0);
            end
            send_pad(random_pad(), i < RANDOM_PADS / 3 || i > RANDOM_PADS / 2);
        end
        drop_valid();

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && sb.pending.size() == 0)
            $display("pad_id_to_position_top regression: pass");
        else
            $display("pad_id_to_position_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/pitp_pkg.sv
hdl/pitp_ctrl.sv
hdl/pitp_dp.sv
hdl/pad_id_to_position_top.sv
sim/pad_id_to_position_top_tb.sv
